>>> rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer: segment and pixel
// payloads, controller/datapath command and status, controller states.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_W = 6;
    localparam int FB_SIZE = 64;

    // Largest remaining-pixel count after the first pixel of a segment
    localparam logic [COORD_W-1:0] MAX_REMAIN = COORD_W'(FB_SIZE - 1);

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pix_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dda_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic last;
    } dda_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } dda_state_t;

endpackage

>>> rtl/dda_datapath.sv
// ----------------------------------------------------------------------------
// dda_datapath
// Segment setup and the integer error-term stepper. Holds the current pixel,
// the error term and the count of pixels still to go.
// ----------------------------------------------------------------------------
module dda_datapath (
    input  logic                clk,
    input  dda_pkg::seg_t       seg,
    input  dda_pkg::dda_cmd_t   cmd,
    output dda_pkg::dda_status_t status,
    output dda_pkg::pix_t       pix
);
    import dda_pkg::*;

    // Setup terms derived from the incoming segment
    logic   dx_neg;
    logic   dy_neg;
    coord_t adx;
    coord_t ady;
    logic   y_major;
    coord_t n_major;
    coord_t m_minor;
    logic   use_ceil;
    coord_t remain_init;

    // Stepper state
    coord_t x_reg, x_next;
    coord_t y_reg, y_next;
    coord_t err_reg, err_next;
    coord_t n_reg, n_next;
    coord_t m_reg, m_next;
    coord_t remain_reg, remain_next;
    logic   y_major_reg, y_major_next;
    logic   x_neg_reg, x_neg_next;
    logic   y_neg_reg, y_neg_next;

    logic [COORD_W:0] err_sum;
    logic             wrap;
    coord_t           err_step;
    coord_t           x_step;
    coord_t           y_step;

    always_comb
    begin
        dx_neg   = seg.end_x < seg.start_x;
        dy_neg   = seg.end_y < seg.start_y;
        adx      = dx_neg ? (seg.start_x - seg.end_x) : (seg.end_x - seg.start_x);
        ady      = dy_neg ? (seg.start_y - seg.end_y) : (seg.end_y - seg.start_y);
        y_major  = ady > adx;
        n_major  = y_major ? ady : adx;
        m_minor  = y_major ? adx : ady;
        // Ceil rounding is floor of (i*m + n - 1) / n: preload the error term
        use_ceil = y_major ? dx_neg : !dy_neg;
        remain_init = (n_major > MAX_REMAIN) ? MAX_REMAIN : n_major;
    end

    always_comb
    begin
        err_sum  = {1'b0, err_reg} + {1'b0, m_reg};
        wrap     = err_sum >= {1'b0, n_reg};
        err_step = wrap ? COORD_W'(err_sum - {1'b0, n_reg}) : err_sum[COORD_W-1:0];
        x_step   = x_neg_reg ? (x_reg - coord_t'(1)) : (x_reg + coord_t'(1));
        y_step   = y_neg_reg ? (y_reg - coord_t'(1)) : (y_reg + coord_t'(1));
    end

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        err_next     = err_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        remain_next  = remain_reg;
        y_major_next = y_major_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        priority if (cmd.load)
        begin
            x_next       = seg.start_x;
            y_next       = seg.start_y;
            err_next     = use_ceil ? (n_major - coord_t'(1)) : '0;
            n_next       = n_major;
            m_next       = m_minor;
            remain_next  = remain_init;
            y_major_next = y_major;
            x_neg_next   = dx_neg;
            y_neg_next   = dy_neg;
        end
        else if (cmd.advance)
        begin
            err_next    = err_step;
            remain_next = remain_reg - coord_t'(1);
            // Major axis always steps; minor axis steps when the error term wraps
            if (y_major_reg)
            begin
                y_next = y_step;
                if (wrap)
                begin
                    x_next = x_step;
                end
            end
            else
            begin
                x_next = x_step;
                if (wrap)
                begin
                    y_next = y_step;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        err_reg     <= err_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        remain_reg  <= remain_next;
        y_major_reg <= y_major_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
    end

    always_comb
    begin
        status.zero_len = n_major == '0;
        status.last     = remain_reg == '0;
        pix.pixel_x     = x_reg;
        pix.pixel_y     = y_reg;
        pix.last_pixel  = remain_reg == '0;
    end

endmodule

>>> rtl/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller for the rasterizer: takes a segment when idle, then presents
// one pixel per cycle while pix_ready is high, until the last pixel transaction completes.
// ----------------------------------------------------------------------------
module dda_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seg_valid,
    output logic                 seg_ready,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    input  dda_pkg::dda_status_t status,
    output dda_pkg::dda_cmd_t    cmd
);
    import dda_pkg::*;

    dda_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Drop zero-length segments without leaving idle
                if (seg_valid && !status.zero_len)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pix_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seg_ready   = 1'b0;
        pix_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                seg_ready = 1'b1;
                cmd.load  = seg_valid;
            end
            ST_RUN:
            begin
                pix_valid   = 1'b1;
                cmd.advance = pix_ready && !status.last;
            end
            default:
            begin
                seg_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// Line segment rasterizer with an exact integer error term in place of the
// fractional DDA accumulator.
// ----------------------------------------------------------------------------
// A segment is taken while the block is idle; its pixels then leave one
// per cycle while pix_ready is high, from start to end, the final one
// flagged by last_pixel, so a segment whose major-axis extent is n takes
// a setup step and then n + 1 pixels (at most 64). The rate is set by the
// single error-term stepper, which advances one pixel per completed pixel
// transaction. A zero-length segment is consumed while idle and produces
// no pixels. The x axis is major when both extents are equal. Pixel
// outputs come straight from registers.
module dda_line_rasterizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           seg_valid,
    output logic           seg_ready,
    input  dda_pkg::seg_t  seg,
    output logic           pix_valid,
    input  logic           pix_ready,
    output dda_pkg::pix_t  pix
);
    import dda_pkg::*;

    dda_cmd_t    cmd;
    dda_status_t status;

    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dda_datapath u_datapath (
        .clk    (clk),
        .seg    (seg),
        .cmd    (cmd),
        .status (status),
        .pix    (pix)
    );

endmodule
